// ===== rtl/oadc_pkg.sv =====
// Shared types, constants and register map for the obstacle-avoid drive controller.
// Used by oadc_div, oadc_ctrl, oadc_dpath and the top level; depends on nothing.
package oadc_pkg;

    // Widths of ports and fields
    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int ECHO_W         = 32;
    localparam int OP_W           = 2;
    localparam int DUTY_W         = 10;
    localparam int DIST_W         = 20;
    localparam int SPEED_W        = 28;
    localparam int SCALE_W        = 12;
    localparam int DIST_CFG_W     = 8;
    localparam int EDGE_CFG_W     = 8;
    localparam int CPM_W          = 16;
    localparam int TICK_W         = 3;
    localparam int DIV_W          = 32;
    localparam int DVS_W          = 16;
    localparam int TDATA_OUT_W    = 120;

    // Saturation limits
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam logic [DUTY_W-1:0]  DUTY_MAX  = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;

    // Control-law constants
    localparam int RAMP_PCT     = 100;
    localparam int DUTY_STEP    = 50;
    localparam int SPEED_MARGIN = 100;
    localparam int TICK_LATCH   = 4;

    // Divide by RAMP_PCT as (x * RECIP_PCT) >> RECIP_SHIFT, exact for x below 2^17
    localparam int               RECIP_W     = 18;
    localparam int               RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_PCT = 18'd167773;

    // Register reset values
    localparam logic [DIST_CFG_W-1:0] MIN_DIST_RST    = 8'd10;
    localparam logic [DIST_CFG_W-1:0] MID_DIST_RST    = 8'd30;
    localparam logic [DUTY_W-1:0]     MAX_DUTY_RST    = 10'd550;
    localparam logic [DUTY_W-1:0]     MIN_DUTY_RST    = 10'd200;
    localparam logic [EDGE_CFG_W-1:0] REV_EDGES_RST   = 8'd30;
    localparam logic [EDGE_CFG_W-1:0] TURN_EDGES_RST  = 8'd45;
    localparam logic [SCALE_W-1:0]    SPEED_SCALE_RST = 12'd834;
    localparam logic [CPM_W-1:0]      CPM_RST         = 16'd4524;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_DIST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REV_EDGES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_EDGES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CPM         = 3'd7;

    typedef enum logic [1:0] {
        OP_EDGE_L = 2'd0,
        OP_EDGE_R = 2'd1,
        OP_TICK   = 2'd2,
        OP_ECHO   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_SLOW = 2'd1,
        MODE_FAST = 2'd2,
        MODE_TURN = 2'd3
    } t_mode;

    // Outcome of the forward rule for the current distance
    typedef enum logic [1:0] {
        FWD_STOP,
        FWD_RAMP,
        FWD_BAL,
        FWD_HOLD
    } t_fwd;

    // Operand select for the shared divider
    typedef enum logic [1:0] {
        DSEL_ECHO,
        DSEL_RATIO
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_ECHO,
        S_ECHO_END,
        S_DIV_RATIO,
        S_MUL,
        S_SCALE,
        S_TURN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic     ld_item;
        logic     edge_inc;
        logic     tick_inc;
        logic     div_start;
        t_div_sel div_sel;
        logic     dist_wr;
        logic     prod_ld;
        logic     speed_latch;
        logic     fwd_stop;
        logic     fwd_bal;
        logic     fwd_ramp;
        logic     turn_step;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic turning;
        t_fwd fwd_case;
        logic div_done;
        logic latch_ok;
    } t_sts;

endpackage

// ===== rtl/oadc_div.sv =====
// Restoring divider for the obstacle-avoid drive controller, one quotient bit a cycle.
// Depends on oadc_pkg for operand widths.
module oadc_div import oadc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DIV_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/oadc_ctrl.sv =====
// Sequencing state machine of the obstacle-avoid drive controller.
// Depends on oadc_pkg; drives oadc_dpath through t_cmd and reads t_sts.
module oadc_ctrl import oadc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_tready;
        o_cmd     = '0;
        o_cmd.div_sel = DSEL_ECHO;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op) inside
                    OP_EDGE_L, OP_EDGE_R: begin
                        o_cmd.edge_inc = 1'b1;
                        n_state = i_sts.turning ? S_TURN : S_DONE;
                    end
                    OP_TICK: begin
                        o_cmd.tick_inc = 1'b1;
                        if (i_sts.turning) begin
                            n_state = S_TURN;
                        end else begin
                            n_state = S_DONE;
                            unique case (i_sts.fwd_case)
                                FWD_STOP: o_cmd.fwd_stop = 1'b1;
                                FWD_BAL:  o_cmd.fwd_bal  = 1'b1;
                                FWD_RAMP: begin
                                    o_cmd.div_start = 1'b1;
                                    o_cmd.div_sel   = DSEL_RATIO;
                                    n_state         = S_DIV_RATIO;
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DSEL_ECHO;
                        n_state         = S_DIV_ECHO;
                    end
                endcase
            end
            S_DIV_ECHO: begin
                if (i_sts.div_done) begin
                    o_cmd.dist_wr = 1'b1;
                    n_state       = S_ECHO_END;
                end
            end
            S_ECHO_END: begin
                o_cmd.speed_latch = i_sts.latch_ok;
                n_state = i_sts.turning ? S_TURN : S_DONE;
            end
            S_DIV_RATIO: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.prod_ld = 1'b1;
                n_state       = S_SCALE;
            end
            // Scale the product down and write the ramp duty
            S_SCALE: begin
                o_cmd.fwd_ramp = 1'b1;
                n_state        = S_DONE;
            end
            S_TURN: begin
                o_cmd.turn_step = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                // Load the result once the output register is free
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_m_valid;

endmodule

// ===== rtl/oadc_dpath.sv =====
// Datapath of the obstacle-avoid drive controller: registers, counters, control law.
// Depends on oadc_pkg and instantiates oadc_div; commanded by oadc_ctrl.
module oadc_dpath import oadc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [OP_W-1:0]        i_op,
    input  logic [ECHO_W-1:0]      i_echo,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [TDATA_OUT_W-1:0] o_tdata
);

    localparam int PROD_W = COUNT_BITS + SCALE_W;
    localparam int EXT_W  = (PROD_W > SPEED_W) ? PROD_W : SPEED_W;
    localparam int RPROD_W = DUTY_W + 9;   // signed span times 8-bit ratio
    localparam int MAG_W   = DUTY_W + 7;   // |span * ratio| stays below 2^17
    localparam int RAMP_W  = DUTY_W + 3;   // signed ramp sum before clamp
    localparam int SCL_W   = MAG_W + RECIP_W;

    // Configuration registers
    logic [DIST_CFG_W-1:0] r_min_dist, r_mid_dist;
    logic [DUTY_W-1:0]     r_max_duty, r_min_duty;
    logic [EDGE_CFG_W-1:0] r_rev_edges, r_turn_edges;
    logic [SCALE_W-1:0]    r_speed_scale;
    logic [CPM_W-1:0]      r_cpm;

    // Event state
    logic [COUNT_BITS-1:0] r_cnt_l, n_cnt_l, r_cnt_r, n_cnt_r;
    logic [TICK_W-1:0]     r_ticks, n_ticks;
    t_mode                 r_mode, n_mode;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic [SPEED_W-1:0]    r_spd_l, n_spd_l, r_spd_r, n_spd_r;
    logic [DUTY_W-1:0]     r_fwd_l, n_fwd_l, r_fwd_r, n_fwd_r;
    logic [DUTY_W-1:0]     r_cmpb_l, n_cmpb_l, r_cmpb_r, n_cmpb_r;
    logic                  r_en, n_en;

    // Item and ramp working registers
    t_op                   r_op;
    logic [ECHO_W-1:0]     r_echo;
    logic                  r_turning;
    logic                  r_neg;
    logic [MAG_W-1:0]      r_mag;
    logic [TDATA_OUT_W-1:0] r_tdata;

    // Divider hookup
    logic [DIV_W-1:0] div_dvd, quo;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;

    // Helpers
    logic [DIST_W-1:0]     min20, mid20;
    t_fwd                  fwd_case;
    logic [DIST_W-1:0]     dist_sat;
    logic [EXT_W-1:0]      p_l, p_r;
    logic [SPEED_W-1:0]    sat_l, sat_r;
    logic [DUTY_W-1:0]     duty_less, bal_l, bal_r;
    logic [SPEED_W:0]      spd_l_ext, spd_r_ext;
    logic [DIST_CFG_W-1:0] dist_diff;
    logic signed [DUTY_W:0]    span;
    logic signed [RPROD_W-1:0] rprod;
    logic [RPROD_W-1:0]        rprod_mag;
    logic [SCL_W-1:0]          scale_prod;
    logic [DUTY_W:0]           ramp_step;
    logic signed [RAMP_W-1:0]  ramp_sum;
    logic [DUTY_W-1:0]         ramp_val;
    logic [DUTY_W:0]           turn_sum;
    logic [DUTY_W-1:0]         turn_val;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist    <= MIN_DIST_RST;
            r_mid_dist    <= MID_DIST_RST;
            r_max_duty    <= MAX_DUTY_RST;
            r_min_duty    <= MIN_DUTY_RST;
            r_rev_edges   <= REV_EDGES_RST;
            r_turn_edges  <= TURN_EDGES_RST;
            r_speed_scale <= SPEED_SCALE_RST;
            r_cpm         <= CPM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_DIST:    r_min_dist    <= i_cfg_data[DIST_CFG_W-1:0];
                REG_MID_DIST:    r_mid_dist    <= i_cfg_data[DIST_CFG_W-1:0];
                REG_MAX_DUTY:    r_max_duty    <= i_cfg_data[DUTY_W-1:0];
                REG_MIN_DUTY:    r_min_duty    <= i_cfg_data[DUTY_W-1:0];
                REG_REV_EDGES:   r_rev_edges   <= i_cfg_data[EDGE_CFG_W-1:0];
                REG_TURN_EDGES:  r_turn_edges  <= i_cfg_data[EDGE_CFG_W-1:0];
                REG_SPEED_SCALE: r_speed_scale <= i_cfg_data[SCALE_W-1:0];
                REG_CPM:         r_cpm         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the distance for the forward rule
    always_comb begin
        min20 = DIST_W'(r_min_dist);
        mid20 = DIST_W'(r_mid_dist);
        if (r_dist < min20 && r_dist != DIST_W'(1)) begin
            fwd_case = FWD_STOP;
        end else if (r_dist > min20 && r_dist < mid20) begin
            fwd_case = FWD_RAMP;
        end else if (r_dist >= mid20 || r_dist == DIST_W'(1)) begin
            fwd_case = FWD_BAL;
        end else begin
            fwd_case = FWD_HOLD;
        end
    end

    // Select divider operands
    always_comb begin
        dist_diff = r_dist[DIST_CFG_W-1:0] - r_min_dist;
        case (i_cmd.div_sel)
            DSEL_RATIO: begin
                div_dvd = DIV_W'(dist_diff) * DIV_W'(RAMP_PCT);
                div_dvs = DVS_W'(r_mid_dist - r_min_dist);
            end
            default: begin
                div_dvd = r_echo;
                div_dvs = r_cpm;
            end
        endcase
    end

    oadc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    // Distance, speed and duty candidates
    always_comb begin
        dist_sat = (|quo[DIV_W-1:DIST_W]) ? DIST_MAX : quo[DIST_W-1:0];

        p_l   = EXT_W'(r_cnt_l) * EXT_W'(r_speed_scale);
        p_r   = EXT_W'(r_cnt_r) * EXT_W'(r_speed_scale);
        sat_l = (p_l > EXT_W'(SPEED_MAX)) ? SPEED_MAX : p_l[SPEED_W-1:0];
        sat_r = (p_r > EXT_W'(SPEED_MAX)) ? SPEED_MAX : p_r[SPEED_W-1:0];

        // Balance: slow the side that runs ahead by the margin
        duty_less = (r_max_duty >= DUTY_W'(DUTY_STEP)) ?
                    r_max_duty - DUTY_W'(DUTY_STEP) : '0;
        spd_l_ext = {1'b0, r_spd_l};
        spd_r_ext = {1'b0, r_spd_r};
        bal_l = r_max_duty;
        bal_r = r_max_duty;
        if (spd_l_ext >= spd_r_ext + (SPEED_W+1)'(SPEED_MARGIN)) begin
            bal_l = duty_less;
        end else if (spd_r_ext >= spd_l_ext + (SPEED_W+1)'(SPEED_MARGIN)) begin
            bal_r = duty_less;
        end

        // Ramp product from the ratio quotient
        span      = $signed({1'b0, r_max_duty}) - $signed({1'b0, r_min_duty});
        rprod     = span * $signed({1'b0, quo[6:0]});
        rprod_mag = rprod[RPROD_W-1] ? RPROD_W'(-rprod) : RPROD_W'(rprod);

        // Divide the magnitude by the percent scale with a reciprocal multiply
        scale_prod = SCL_W'(r_mag) * SCL_W'(RECIP_PCT);
        ramp_step  = scale_prod[RECIP_SHIFT +: DUTY_W+1];

        // Ramp result: sign back on, add the floor, clamp
        if (r_neg) begin
            ramp_sum = $signed(RAMP_W'(r_min_duty)) - $signed(RAMP_W'(ramp_step));
        end else begin
            ramp_sum = $signed(RAMP_W'(r_min_duty)) + $signed(RAMP_W'(ramp_step));
        end
        if (ramp_sum < 0) begin
            ramp_val = '0;
        end else if (ramp_sum > $signed(RAMP_W'(DUTY_MAX))) begin
            ramp_val = DUTY_MAX;
        end else begin
            ramp_val = ramp_sum[DUTY_W-1:0];
        end

        turn_sum = {1'b0, r_min_duty} + (DUTY_W+1)'(DUTY_STEP);
        turn_val = turn_sum[DUTY_W] ? DUTY_MAX : turn_sum[DUTY_W-1:0];
    end

    // Next event state
    always_comb begin
        n_cnt_l  = r_cnt_l;
        n_cnt_r  = r_cnt_r;
        n_ticks  = r_ticks;
        n_mode   = r_mode;
        n_dist   = r_dist;
        n_spd_l  = r_spd_l;
        n_spd_r  = r_spd_r;
        n_fwd_l  = r_fwd_l;
        n_fwd_r  = r_fwd_r;
        n_cmpb_l = r_cmpb_l;
        n_cmpb_r = r_cmpb_r;
        n_en     = r_en;

        // Count tach edges, saturating
        if (i_cmd.edge_inc) begin
            if (r_op == OP_EDGE_L && r_cnt_l != '1) begin
                n_cnt_l = r_cnt_l + 1'b1;
            end
            if (r_op == OP_EDGE_R && r_cnt_r != '1) begin
                n_cnt_r = r_cnt_r + 1'b1;
            end
        end
        if (i_cmd.tick_inc && r_ticks != TICK_MAX) begin
            n_ticks = r_ticks + 1'b1;
        end
        if (i_cmd.dist_wr) begin
            n_dist = dist_sat;
        end
        // Latch speeds and restart the window
        if (i_cmd.speed_latch) begin
            n_spd_l = sat_l;
            n_spd_r = sat_r;
            n_cnt_l = '0;
            n_cnt_r = '0;
            n_ticks = '0;
        end
        if (i_cmd.fwd_stop) begin
            n_fwd_l  = '0;
            n_fwd_r  = '0;
            n_cmpb_l = '0;
            n_cmpb_r = '0;
            n_en     = 1'b0;
            n_mode   = MODE_TURN;
        end
        // Compare B is cross-wired to the opposite forward duty
        if (i_cmd.fwd_bal) begin
            n_fwd_l  = bal_l;
            n_fwd_r  = bal_r;
            n_cmpb_l = bal_r;
            n_cmpb_r = bal_l;
            n_en     = 1'b1;
            n_mode   = MODE_FAST;
        end
        if (i_cmd.fwd_ramp) begin
            n_fwd_l  = ramp_val;
            n_fwd_r  = ramp_val;
            n_cmpb_l = ramp_val;
            n_cmpb_r = ramp_val;
            n_en     = 1'b1;
            n_mode   = MODE_SLOW;
        end
        // Back up, then pivot, then resume on the side-1 count
        if (i_cmd.turn_step) begin
            if (r_cnt_l < COUNT_BITS'(r_rev_edges)) begin
                n_fwd_l  = '0;
                n_fwd_r  = '0;
                n_cmpb_l = r_min_duty;
                n_cmpb_r = r_min_duty;
                n_en     = 1'b1;
            end else if (r_cnt_l < COUNT_BITS'(r_turn_edges)) begin
                n_fwd_l  = turn_val;
                n_fwd_r  = '0;
                n_cmpb_l = '0;
                n_cmpb_r = turn_val;
                n_en     = 1'b1;
            end else begin
                n_fwd_l  = '0;
                n_fwd_r  = '0;
                n_cmpb_l = '0;
                n_cmpb_r = '0;
                n_en     = 1'b0;
                n_cnt_l  = '0;
                n_cnt_r  = '0;
                n_mode   = MODE_FAST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_l  <= '0;
            r_cnt_r  <= '0;
            r_ticks  <= '0;
            r_mode   <= MODE_STOP;
            r_dist   <= '0;
            r_spd_l  <= '0;
            r_spd_r  <= '0;
            r_fwd_l  <= '0;
            r_fwd_r  <= '0;
            r_cmpb_l <= '0;
            r_cmpb_r <= '0;
            r_en     <= 1'b0;
        end else begin
            r_cnt_l  <= n_cnt_l;
            r_cnt_r  <= n_cnt_r;
            r_ticks  <= n_ticks;
            r_mode   <= n_mode;
            r_dist   <= n_dist;
            r_spd_l  <= n_spd_l;
            r_spd_r  <= n_spd_r;
            r_fwd_l  <= n_fwd_l;
            r_fwd_r  <= n_fwd_r;
            r_cmpb_l <= n_cmpb_l;
            r_cmpb_r <= n_cmpb_r;
            r_en     <= n_en;
        end
    end

    // Capture the item, the ramp magnitude and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_op      <= t_op'(i_op);
            r_echo    <= i_echo;
            r_turning <= (r_mode == MODE_TURN);
        end
        if (i_cmd.prod_ld) begin
            r_neg <= rprod[RPROD_W-1];
            r_mag <= rprod_mag[MAG_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_tdata <= {1'b0, r_spd_r, r_spd_l, r_dist, r_mode, r_en,
                        r_cmpb_r, r_cmpb_l, r_fwd_r, r_fwd_l};
        end
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.turning  = r_turning;
        o_sts.fwd_case = fwd_case;
        o_sts.div_done = div_done;
        o_sts.latch_ok = (r_ticks > TICK_W'(TICK_LATCH)) && !r_turning;
    end

    assign o_tdata = r_tdata;

endmodule

// ===== rtl/obstacle_avoid_drive_controller.sv =====
// Obstacle-avoid drive controller: one result transaction for every event transaction.
// Edge, stop, balance and hold events go from decode straight to the result load; echo
// events first run the 32-step serial divider; ticks in the ramp band take one divider
// pass, a product and a reciprocal scale step. A turn step precedes the load while turning.
// One event in work at a time; the next is taken the cycle after its result loads, and
// the load waits while an earlier result is still held downstream. Reset (synchronous,
// active low) clears counters, speeds, duties, distance and mode, and loads the
// configuration registers with their defaults.
module obstacle_avoid_drive_controller import oadc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // echo_counts[31:0]
    input  logic [ECHO_W-1:0]      s_axis_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // fwd_duty_left[9:0], fwd_duty_right[19:10], cmp_b_left[29:20], cmp_b_right[39:30],
    // drive_enable[40], car_mode[42:41], distance_cm[62:43], speed_left[90:63],
    // speed_right[118:91], zero pad [119]
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    oadc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    oadc_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_op       (s_axis_tuser),
        .i_echo     (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_tdata    (m_axis_tdata)
    );

endmodule
